>>> hw/rtl/owec_pkg.sv
// Shared constants, codes and the CRC16 byte update of the 1-Wire EEPROM command engine.
package owec_pkg;

	localparam int MEMORY_BYTES = 512;
	localparam int PAGE_BYTES = 32;
	localparam int AW = $clog2(MEMORY_BYTES);
	localparam int PW = $clog2(PAGE_BYTES);

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_END = 2'd3;

	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_UNKNOWN = 2'd1;
	localparam logic [1:0] STS_MISMATCH = 2'd2;
	localparam logic [1:0] STS_PF_REFUSED = 2'd3;

	localparam logic [7:0] CMD_IDLE = 8'h00;
	localparam logic [7:0] CMD_AWAIT = 8'h01;
	localparam logic [7:0] CMD_WRITE_SP = 8'h0F;
	localparam logic [7:0] CMD_COPY_SP = 8'h55;
	localparam logic [7:0] CMD_READ_SP = 8'hAA;
	localparam logic [7:0] CMD_READ_MEM = 8'hF0;
	localparam logic [7:0] COPY_ANSWER = 8'b10101010;

	localparam logic [7:0] ES_PF = 8'h20;
	localparam logic [7:0] ES_AA = 8'h80;
	localparam logic [7:0] ES_RESET = 8'd31;

	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ 16'hA001;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/owec_req_if.sv
// Request channel carrying one bus event into the command engine.
interface owec_req_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [7:0] wr_byte;
	logic partial_byte;

	modport source(output valid, output opcode, output wr_byte, output partial_byte, input ready);
	modport sink(input valid, input opcode, input wr_byte, input partial_byte, output ready);
endinterface

>>> hw/rtl/owec_rsp_if.sv
// Response channel carrying one result of the command engine.
interface owec_rsp_if;
	logic valid;
	logic ready;
	logic [7:0] rd_byte;
	logic [1:0] status;
	logic copy_done;

	modport source(output valid, output rd_byte, output status, output copy_done, input ready);
	modport sink(input valid, input rd_byte, input status, input copy_done, output ready);
endinterface

>>> hw/rtl/onewire_eeprom_command_engine.sv
// Function layer of a 1-Wire EEPROM: command decode, scratchpad, CRC16 and memory array.
//
// channel | dir | payload
// req     | in  | opcode, wr_byte, partial_byte
// rsp     | out | rd_byte, status, copy_done
//
// A result is registered at the edge that takes its request, but for memory reads and copies that move bytes.
// A memory read passes the registered read port (rdata_q), then the response register.
// A copy that moves bytes writes them in turn in ST_COPY, at least one and up to 32, then answers.
// After reset a clearing pass writes zero to each of the 512 array bytes, one
// per cycle, and no request is taken until it ends.
// A new request is taken only when the engine is idle and the response register is empty or its result leaves.
module onewire_eeprom_command_engine
	import owec_pkg::*;
(
	input logic clk,
	input logic arst_n,
	owec_req_if.sink req,
	owec_rsp_if.source rsp
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_MEMRD = 2'd2;
	localparam logic [1:0] ST_COPY = 2'd3;
	localparam logic [15:0] MEM_LIMIT = 16'(MEMORY_BYTES);
	localparam logic [15:0] MEM_LAST = 16'(MEMORY_BYTES - 1);
	localparam logic [15:0] PAGE_LIMIT = 16'(PAGE_BYTES);
	localparam logic [15:0] OFS_MASK = 16'(PAGE_BYTES - 1);

	logic [1:0] state_q, state_n;
	logic [AW-1:0] clr_q;
	logic [15:0] ta_q, ta_n;
	logic [7:0] es_q, es_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0] cmd_q, cmd_n;
	logic [3:0] ph_q, ph_n;
	logic [15:0] ptr_q, ptr_n;
	logic [PW-1:0] idx_q;
	logic [15:0] pos_q;
	logic [7:0] sp_q [PAGE_BYTES];
	logic [7:0] mem [MEMORY_BYTES];
	logic [7:0] rdata_q;
	logic out_valid_q;
	logic [7:0] out_rd_q;
	logic [1:0] out_st_q;
	logic out_done_q;

	logic accept;
	logic [7:0] o_rd;
	logic [1:0] o_st;
	logic o_done;
	logic go_mem, go_copy, sp_we;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0] mem_wd;
	logic [15:0] ta_new;
	logic [15:0] inv;
	logic copy_last;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.rd_byte = out_rd_q;
	assign rsp.status = out_st_q;
	assign rsp.copy_done = out_done_q;

	assign inv = ~crc_q;
	assign ta_new = {req.wr_byte, ta_q[7:0]};
	assign copy_last = (idx_q == es_q[PW-1:0]) || (pos_q >= MEM_LAST);

	always_comb begin
		ta_n = ta_q;
		es_n = es_q;
		crc_n = crc_q;
		cmd_n = cmd_q;
		ph_n = ph_q;
		ptr_n = ptr_q;
		o_rd = 8'hFF;
		o_st = STS_OK;
		o_done = 1'b0;
		go_mem = 1'b0;
		go_copy = 1'b0;
		sp_we = 1'b0;
		case (req.opcode)
			OP_START: begin
				cmd_n = CMD_AWAIT;
				ph_n = 4'd0;
				crc_n = 16'd0;
				ptr_n = 16'd0;
			end
			OP_END: begin
				if (req.partial_byte && cmd_q == CMD_WRITE_SP && ph_q == 4'd2 &&
						ptr_q < PAGE_LIMIT) begin
					es_n = es_q | ES_PF;
				end
				cmd_n = CMD_IDLE;
				ph_n = 4'd0;
			end
			OP_WRITE: begin
				case (cmd_q)
					CMD_AWAIT: begin
						crc_n = crc16_byte(crc_q, req.wr_byte);
						ph_n = 4'd0;
						if (req.wr_byte == CMD_WRITE_SP || req.wr_byte == CMD_COPY_SP ||
								req.wr_byte == CMD_READ_SP || req.wr_byte == CMD_READ_MEM) begin
							cmd_n = req.wr_byte;
						end else begin
							cmd_n = CMD_IDLE;
							o_st = STS_UNKNOWN;
						end
					end
					CMD_WRITE_SP: begin
						if (ph_q == 4'd0) begin
							crc_n = crc16_byte(crc_q, req.wr_byte);
							ta_n = {8'h00, req.wr_byte};
							ph_n = 4'd1;
						end else if (ph_q == 4'd1) begin
							crc_n = crc16_byte(crc_q, req.wr_byte);
							ta_n = ta_new & MEM_LAST;
							ptr_n = ta_n & OFS_MASK;
							es_n = 8'((ptr_n - 16'd1) & OFS_MASK);
							ph_n = 4'd2;
						end else if (ph_q == 4'd2 && ptr_q < PAGE_LIMIT) begin
							crc_n = crc16_byte(crc_q, req.wr_byte);
							sp_we = 1'b1;
							es_n = 8'(ptr_q & OFS_MASK);
							ptr_n = ptr_q + 16'd1;
						end
					end
					CMD_COPY_SP: begin
						if (ph_q == 4'd0) begin
							if (req.wr_byte != ta_q[7:0]) begin
								o_st = STS_MISMATCH;
								cmd_n = CMD_IDLE;
							end else begin
								ph_n = 4'd1;
							end
						end else if (ph_q == 4'd1) begin
							if (req.wr_byte != ta_q[15:8]) begin
								o_st = STS_MISMATCH;
								cmd_n = CMD_IDLE;
							end else begin
								ph_n = 4'd2;
							end
						end else if (ph_q == 4'd2) begin
							if (req.wr_byte != es_q) begin
								o_st = STS_MISMATCH;
								cmd_n = CMD_IDLE;
							end else if ((es_q & ES_PF) != 8'h00) begin
								o_st = STS_PF_REFUSED;
								cmd_n = CMD_IDLE;
							end else begin
								es_n = es_q | ES_AA;
								o_done = 1'b1;
								ph_n = 4'd3;
								go_copy = es_q[PW-1:0] >= ta_q[PW-1:0];
							end
						end
					end
					CMD_READ_MEM: begin
						if (ph_q == 4'd0) begin
							ta_n = {8'h00, req.wr_byte};
							ph_n = 4'd1;
						end else if (ph_q == 4'd1) begin
							ta_n = ta_new;
							ptr_n = ta_new;
							ph_n = 4'd2;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
				case (cmd_q)
					CMD_WRITE_SP: begin
						if (ph_q == 4'd2) begin
							o_rd = inv[7:0];
							ph_n = 4'd3;
						end else if (ph_q == 4'd3) begin
							o_rd = inv[15:8];
							ph_n = 4'd4;
						end
					end
					CMD_COPY_SP: begin
						if (ph_q == 4'd3) begin
							o_rd = COPY_ANSWER;
						end
					end
					CMD_READ_SP: begin
						if (ph_q == 4'd0) begin
							o_rd = ta_q[7:0];
							ph_n = 4'd1;
						end else if (ph_q == 4'd1) begin
							o_rd = ta_q[15:8];
							ph_n = 4'd2;
						end else if (ph_q == 4'd2) begin
							o_rd = es_q;
							ptr_n = ta_q & OFS_MASK;
							ph_n = 4'd3;
						end else if (ptr_q < PAGE_LIMIT) begin
							o_rd = sp_q[ptr_q[PW-1:0]];
							ptr_n = ptr_q + 16'd1;
						end
					end
					CMD_READ_MEM: begin
						if (ph_q == 4'd2 && ptr_q < MEM_LIMIT) begin
							go_mem = 1'b1;
							ptr_n = ptr_q + 16'd1;
						end
					end
					default: begin
					end
				endcase
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(MEMORY_BYTES - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && go_mem) begin
					state_n = ST_MEMRD;
				end else if (accept && go_copy) begin
					state_n = ST_COPY;
				end
			end
			ST_MEMRD: begin
				state_n = ST_IDLE;
			end
			ST_COPY: begin
				if (copy_last) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = 8'h00;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_COPY) begin
			mem_we = pos_q < MEM_LIMIT;
			mem_wa = pos_q[AW-1:0];
			mem_wd = sp_q[idx_q];
		end
		mem_ra = ptr_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ta_q <= 16'd0;
			es_q <= ES_RESET;
			crc_q <= 16'd0;
			cmd_q <= CMD_IDLE;
			ph_q <= 4'd0;
			ptr_q <= 16'd0;
			idx_q <= '0;
			pos_q <= 16'd0;
			out_valid_q <= 1'b0;
			out_rd_q <= 8'hFF;
			out_st_q <= STS_OK;
			out_done_q <= 1'b0;
			for (int i = 0; i < PAGE_BYTES; i++) begin
				sp_q[i] <= 8'h00;
			end
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				ta_q <= ta_n;
				es_q <= es_n;
				crc_q <= crc_n;
				cmd_q <= cmd_n;
				ph_q <= ph_n;
				ptr_q <= ptr_n;
				if (sp_we) begin
					sp_q[ptr_q[PW-1:0]] <= req.wr_byte;
				end
				idx_q <= ta_q[PW-1:0];
				pos_q <= ta_q;
			end
			if (state_q == ST_COPY) begin
				idx_q <= idx_q + PW'(1);
				pos_q <= pos_q + 16'd1;
			end
			if (accept && !go_mem && !go_copy) begin
				out_valid_q <= 1'b1;
				out_rd_q <= o_rd;
				out_st_q <= o_st;
				out_done_q <= o_done;
			end else if (state_q == ST_MEMRD) begin
				out_valid_q <= 1'b1;
				out_rd_q <= rdata_q;
				out_st_q <= STS_OK;
				out_done_q <= 1'b0;
			end else if (state_q == ST_COPY && copy_last) begin
				out_valid_q <= 1'b1;
				out_rd_q <= 8'hFF;
				out_st_q <= STS_OK;
				out_done_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> state_q == ST_IDLE)
		else $error("request taken while the engine is busy");
	a_memrd_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MEMRD |=> out_valid_q && !out_done_q)
		else $error("memory read produced no result");
	a_mem_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_CLEAR || state_q == ST_COPY)
		else $error("array written outside clearing or copy");
	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY && mem_we |-> pos_q < MEM_LIMIT)
		else $error("copy wrote past the end of the array");
`endif

endmodule

>>> bench/tb_onewire_eeprom_command_engine.sv
// Self-checking testbench of the 1-Wire EEPROM command engine with a built-in predictor.
`timescale 1ns / 1ps

module tb_onewire_eeprom_command_engine
	import owec_pkg::*;
();

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] wr_byte;
		logic partial_byte;
	} bus_event_t;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic [1:0] status;
		logic copy_done;
	} answer_t;

	logic clk;
	logic arst_n;
	owec_req_if req ();
	owec_rsp_if rsp ();

	onewire_eeprom_command_engine i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	// Predictor state.
	logic [7:0] mem_img [MEMORY_BYTES];
	logic [7:0] pad_img [PAGE_BYTES];
	logic [15:0] ta_img;
	logic [7:0] es_img;
	logic [15:0] crc_img;
	logic [7:0] cmd_img;
	logic [3:0] phase_img;
	logic [15:0] ptr_img;

	bus_event_t pending_events [$];
	answer_t expected_answers [$];
	int unsigned mismatches;
	int unsigned answers_seen;
	int unsigned copies_seen;
	bit quiet_phase;
	bit hold_off;

	always #1 clk = ~clk;

	initial begin
		#200000000;
		$display("tb_onewire_eeprom_command_engine: done, errors");
		$finish;
	end

	// The receiver holds off for a long stretch once traffic is well underway.
	initial begin
		hold_off = 1'b0;
		wait (answers_seen >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void copy_page();
		int first;
		int last;
		int pos;
		first = ta_img % PAGE_BYTES;
		last = es_img % PAGE_BYTES;
		pos = ta_img;
		if (last < first) begin
			return;
		end
		for (int i = first; i <= last && i < PAGE_BYTES; i++) begin
			if (pos >= MEMORY_BYTES) begin
				break;
			end
			mem_img[pos] = pad_img[i];
			pos++;
		end
	endfunction

	function automatic answer_t predict_event(input bus_event_t ev);
		answer_t a;
		logic [15:0] inv;
		a = '{rd_byte: 8'hFF, status: STS_OK, copy_done: 1'b0};
		case (ev.opcode)
			OP_START: begin
				cmd_img = CMD_AWAIT;
				phase_img = 4'd0;
				crc_img = 16'd0;
				ptr_img = 16'd0;
			end
			OP_END: begin
				if (ev.partial_byte && cmd_img == CMD_WRITE_SP && phase_img == 4'd2 &&
						ptr_img < PAGE_BYTES) begin
					es_img = es_img | ES_PF;
				end
				cmd_img = CMD_IDLE;
				phase_img = 4'd0;
			end
			OP_WRITE: begin
				case (cmd_img)
					CMD_AWAIT: begin
						crc_img = crc_update(crc_img, ev.wr_byte);
						phase_img = 4'd0;
						if (ev.wr_byte == CMD_WRITE_SP || ev.wr_byte == CMD_COPY_SP ||
								ev.wr_byte == CMD_READ_SP || ev.wr_byte == CMD_READ_MEM) begin
							cmd_img = ev.wr_byte;
						end else begin
							cmd_img = CMD_IDLE;
							a.status = STS_UNKNOWN;
						end
					end
					CMD_WRITE_SP: begin
						if (phase_img == 4'd0) begin
							crc_img = crc_update(crc_img, ev.wr_byte);
							ta_img = {8'h00, ev.wr_byte};
							phase_img = 4'd1;
						end else if (phase_img == 4'd1) begin
							crc_img = crc_update(crc_img, ev.wr_byte);
							ta_img = {ev.wr_byte, ta_img[7:0]} & 16'(MEMORY_BYTES - 1);
							ptr_img = ta_img & 16'(PAGE_BYTES - 1);
							es_img = 8'((ptr_img - 16'd1) & 16'(PAGE_BYTES - 1));
							phase_img = 4'd2;
						end else if (phase_img == 4'd2 && ptr_img < PAGE_BYTES) begin
							crc_img = crc_update(crc_img, ev.wr_byte);
							pad_img[ptr_img[PW-1:0]] = ev.wr_byte;
							es_img = 8'(ptr_img & 16'(PAGE_BYTES - 1));
							ptr_img++;
						end
					end
					CMD_COPY_SP: begin
						if (phase_img == 4'd0) begin
							if (ev.wr_byte != ta_img[7:0]) begin
								a.status = STS_MISMATCH;
								cmd_img = CMD_IDLE;
							end else begin
								phase_img = 4'd1;
							end
						end else if (phase_img == 4'd1) begin
							if (ev.wr_byte != ta_img[15:8]) begin
								a.status = STS_MISMATCH;
								cmd_img = CMD_IDLE;
							end else begin
								phase_img = 4'd2;
							end
						end else if (phase_img == 4'd2) begin
							if (ev.wr_byte != es_img) begin
								a.status = STS_MISMATCH;
								cmd_img = CMD_IDLE;
							end else if ((es_img & ES_PF) != 8'h00) begin
								a.status = STS_PF_REFUSED;
								cmd_img = CMD_IDLE;
							end else begin
								es_img = es_img | ES_AA;
								copy_page();
								a.copy_done = 1'b1;
								phase_img = 4'd3;
							end
						end
					end
					CMD_READ_MEM: begin
						if (phase_img == 4'd0) begin
							ta_img = {8'h00, ev.wr_byte};
							phase_img = 4'd1;
						end else if (phase_img == 4'd1) begin
							ta_img = {ev.wr_byte, ta_img[7:0]};
							ptr_img = ta_img;
							phase_img = 4'd2;
						end
					end
					default: ;
				endcase
			end
			default: begin
				case (cmd_img)
					CMD_WRITE_SP: begin
						inv = ~crc_img;
						if (phase_img == 4'd2) begin
							a.rd_byte = inv[7:0];
							phase_img = 4'd3;
						end else if (phase_img == 4'd3) begin
							a.rd_byte = inv[15:8];
							phase_img = 4'd4;
						end
					end
					CMD_COPY_SP: begin
						if (phase_img == 4'd3) begin
							a.rd_byte = COPY_ANSWER;
						end
					end
					CMD_READ_SP: begin
						if (phase_img == 4'd0) begin
							a.rd_byte = ta_img[7:0];
							phase_img = 4'd1;
						end else if (phase_img == 4'd1) begin
							a.rd_byte = ta_img[15:8];
							phase_img = 4'd2;
						end else if (phase_img == 4'd2) begin
							a.rd_byte = es_img;
							ptr_img = ta_img & 16'(PAGE_BYTES - 1);
							phase_img = 4'd3;
						end else if (ptr_img < PAGE_BYTES) begin
							a.rd_byte = pad_img[ptr_img[PW-1:0]];
							ptr_img++;
						end
					end
					CMD_READ_MEM: begin
						if (phase_img == 4'd2 && ptr_img < MEMORY_BYTES) begin
							a.rd_byte = mem_img[ptr_img[AW-1:0]];
							ptr_img++;
						end
					end
					default: ;
				endcase
			end
		endcase
		return a;
	endfunction

	function automatic bus_event_t mk(input logic [1:0] op, input logic [7:0] b,
			input logic pb);
		bus_event_t ev;
		ev.opcode = op;
		ev.wr_byte = b;
		ev.partial_byte = pb;
		return ev;
	endfunction

	task automatic push(input logic [1:0] op, input logic [7:0] b, input logic pb);
		pending_events.push_back(mk(op, b, pb));
	endtask

	task automatic push_write(input logic [7:0] b);
		push(OP_WRITE, b, 1'($urandom_range(0, 1)));
	endtask

	task automatic push_read();
		push(OP_READ, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Tracks the device-side scratchpad state as the sequences are built, so copy
	// echoes usually match.
	logic [15:0] gen_ta;
	logic [7:0] gen_es;

	task automatic gen_write_sp(input logic [15:0] addr, input int nbytes,
			input bit partial_end);
		int off;
		push(OP_START, 8'($urandom), 1'($urandom_range(0, 1)));
		push_write(CMD_WRITE_SP);
		push_write(addr[7:0]);
		push_write(addr[15:8]);
		gen_ta = addr & 16'(MEMORY_BYTES - 1);
		off = gen_ta % PAGE_BYTES;
		gen_es = 8'((off - 1) & (PAGE_BYTES - 1));
		for (int i = 0; i < nbytes; i++) begin
			push_write(8'($urandom));
			if (off < PAGE_BYTES) begin
				gen_es = 8'(off);
				off++;
			end
		end
		if (partial_end && off < PAGE_BYTES) begin
			gen_es = gen_es | ES_PF;
		end
		if (!partial_end && $urandom_range(0, 2) != 0) begin
			push_read();
			push_read();
			push_read();
		end
		push(OP_END, 8'($urandom), partial_end);
	endtask

	task automatic gen_copy(input bit corrupt);
		logic [7:0] es_echo;
		int which;
		which = $urandom_range(0, 2);
		es_echo = gen_es;
		push(OP_START, 8'($urandom), 1'b0);
		push_write(CMD_COPY_SP);
		push_write((corrupt && which == 0) ? ~gen_ta[7:0] : gen_ta[7:0]);
		push_write((corrupt && which == 1) ? ~gen_ta[15:8] : gen_ta[15:8]);
		push_write((corrupt && which == 2) ? ~es_echo : es_echo);
		push_read();
		push_read();
		if (!corrupt && !(gen_es & ES_PF)) begin
			gen_es = gen_es | ES_AA;
		end
		push(OP_END, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic gen_read_sp(input int nreads);
		push(OP_START, 8'($urandom), 1'b0);
		push_write(CMD_READ_SP);
		for (int i = 0; i < nreads; i++) begin
			push_read();
		end
		push(OP_END, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic gen_read_mem(input logic [15:0] addr, input int nreads);
		push(OP_START, 8'($urandom), 1'b0);
		push_write(CMD_READ_MEM);
		push_write(addr[7:0]);
		push_write(addr[15:8]);
		for (int i = 0; i < nreads; i++) begin
			push_read();
		end
		push(OP_END, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	task automatic gen_noise(input int n);
		for (int i = 0; i < n; i++) begin
			push(2'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	// Driver with random idle bursts.
	int unsigned send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_END;
			req.wr_byte <= 8'h00;
			req.partial_byte <= 1'b0;
			send_gap <= 0;
		end else if (!req.valid || req.ready) begin
			if (req.valid) begin
				expected_answers.push_back(predict_event(
					mk(req.opcode, req.wr_byte, req.partial_byte)));
			end
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				req.valid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				bus_event_t ev;
				ev = pending_events.pop_front();
				req.valid <= 1'b1;
				req.opcode <= ev.opcode;
				req.wr_byte <= ev.wr_byte;
				req.partial_byte <= ev.partial_byte;
				if (!quiet_phase && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(1, 18);
				end
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Monitor with random stall bursts and one long hold-off.
	int unsigned stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				answer_t got;
				answer_t exp;
				got = '{rd_byte: rsp.rd_byte, status: rsp.status, copy_done: rsp.copy_done};
				answers_seen++;
				if (got.copy_done) begin
					copies_seen++;
				end
				if (expected_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected response: rd=%h st=%0d done=%0d",
							got.rd_byte, got.status, got.copy_done);
					end
				end else begin
					exp = expected_answers.pop_front();
					if (got !== exp) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: exp rd=%h st=%0d done=%0d, got rd=%h st=%0d done=%0d",
								exp.rd_byte, exp.status, exp.copy_done,
								got.rd_byte, got.status, got.copy_done);
						end
					end
				end
			end
			if (hold_off) begin
				rsp.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				rsp.ready <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(1, 18) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	initial begin
		int kind;
		clk = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		answers_seen = 0;
		copies_seen = 0;
		quiet_phase = 1'b0;
		for (int i = 0; i < MEMORY_BYTES; i++) begin
			mem_img[i] = 8'h00;
		end
		for (int i = 0; i < PAGE_BYTES; i++) begin
			pad_img[i] = 8'h00;
		end
		ta_img = 16'd0;
		es_img = ES_RESET;
		crc_img = 16'd0;
		cmd_img = CMD_IDLE;
		phase_img = 4'd0;
		ptr_img = 16'd0;
		gen_ta = 16'd0;
		gen_es = ES_RESET;

		// Directed: reads out of phase, unknown command, full page at the top of
		// memory and its copy, memory read past the end, partial byte refusal, bad echo.
		push(OP_READ, 8'hFF, 1'b1);
		push(OP_WRITE, 8'h00, 1'b0);
		gen_read_sp(4);
		push(OP_START, 8'h00, 1'b0);
		push_write(8'h33);
		push_read();
		gen_write_sp(16'hFFE0, 33, 1'b0);
		gen_copy(1'b0);
		gen_read_mem(16'h01FE, 3);
		gen_write_sp(16'h0105, 2, 1'b1);
		gen_copy(1'b0);
		gen_copy(1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int n = 0; n < 1700 && pending_events.size() < 1700; ) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: gen_write_sp(($urandom_range(0, 7) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, MEMORY_BYTES - 1)),
					($urandom_range(0, 5) == 0) ? $urandom_range(30, 36)
					: $urandom_range(0, 10), $urandom_range(0, 7) == 0);
				3, 4: gen_copy($urandom_range(0, 5) == 0);
				5: gen_read_sp($urandom_range(0, 40));
				6, 7: gen_read_mem(($urandom_range(0, 7) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, MEMORY_BYTES - 1)), $urandom_range(0, 8));
				default: gen_noise($urandom_range(1, 6));
			endcase
			n = pending_events.size();
		end

		wait (pending_events.size() < 250);
		quiet_phase = 1'b1;

		wait (pending_events.size() == 0 && !req.valid && expected_answers.size() == 0);
		repeat (100) @(posedge clk);
		$display("Covered %0d responses including %0d completed copies.",
			answers_seen, copies_seen);
		if (mismatches == 0) begin
			$display("tb_onewire_eeprom_command_engine: done, clean");
		end else begin
			$display("tb_onewire_eeprom_command_engine: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/owec_pkg.sv
hw/rtl/owec_req_if.sv
hw/rtl/owec_rsp_if.sv
hw/rtl/onewire_eeprom_command_engine.sv
bench/tb_onewire_eeprom_command_engine.sv
